@@ rtl/rgac_pkg.sv @@
// shared types and constants for the resource grant arbiter with cooldown
// no dependencies; imported by every module of the block
package rgac_pkg;

    // input action codes
    localparam logic [1:0] ACT_TICK     = 2'd0;
    localparam logic [1:0] ACT_REQUEST  = 2'd1;
    localparam logic [1:0] ACT_RELEASE  = 2'd2;
    localparam logic [1:0] ACT_WITHDRAW = 2'd3;

    // configuration register indexes (paddr[3:2])
    localparam logic [1:0] REG_POLICY   = 2'd0;
    localparam logic [1:0] REG_COOLDOWN = 2'd1;
    localparam logic [1:0] REG_BURNOUT  = 2'd2;

    // policy codes
    localparam logic POL_ARRIVAL  = 1'b0;
    localparam logic POL_DEADLINE = 1'b1;

    localparam int TIME_W  = 32;
    localparam int ID_W    = 8;
    localparam int COUNT_W = 5;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    // one waiter slot
    typedef struct packed {
        logic [ID_W-1:0]   owner;
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] deadline;
    } slot_entry_t;

    // result of the shared key compare unit
    typedef struct packed {
        logic lt;
        logic eq;
    } cmp_res_t;

endpackage

@@ rtl/resource_grant_arbiter_cooldown.sv @@
// top level of the resource grant arbiter with cooldown: apb registers,
// sequencer and result registers; uses rgac_pkg, rgac_slots and rgac_cmp
//
// Start is taken when start is high and busy is low; one result follows each
// request, shown for exactly one cycle with done high, and the receiver cannot
// stall it. For a tick, request or release, the action state applies the action,
// then a single shared key comparator visits one waiter slot per cycle to find
// the winner, then the grant state applies the grant and registers the result.
// A withdraw adds a search before the scan, as the same comparator searches the
// slots for the requester's identity.
// busy stays high until done, and the next start may be taken in the done cycle.
// Configuration: policy at 0x0, cooldown_ms at 0x4, burnout_ms at 0x8.
module resource_grant_arbiter_cooldown
    import rgac_pkg::*;
#(
    parameter int WAITER_SLOTS = 2
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          action,
    input  logic [ID_W-1:0]     requester_id,
    input  logic [TIME_W-1:0]   compile_start,
    output logic                done,
    output logic                granted,
    output logic [ID_W-1:0]     grant_id,
    output logic                rejected,
    output logic                busy_res,
    output logic [COUNT_W-1:0]  waiting
);

    localparam int IDX_W = (WAITER_SLOTS > 2) ? $clog2(WAITER_SLOTS) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WAITER_SLOTS - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ACT   = 3'd1;
    localparam logic [2:0] S_WDRAW = 3'd2;
    localparam logic [2:0] S_PICK  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    // configuration registers
    logic        policy_reg;
    logic [15:0] cooldown_reg;
    logic [15:0] burnout_reg;
    logic        cfg_wr;

    // control state
    logic [2:0]        state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic              held_reg, held_next;
    logic              ever_rel_reg, ever_rel_next;
    logic [TIME_W-1:0] rel_time_reg, rel_time_next;
    logic              best_valid_reg, best_valid_next;
    logic              rej_reg, rej_next;

    // payload captured with the request and scan results
    logic [1:0]        act_reg;
    logic [ID_W-1:0]   id_reg;
    logic [TIME_W-1:0] start_reg;
    logic [IDX_W-1:0]  best_idx_reg, best_idx_next;
    logic [TIME_W-1:0] lead_key_reg, lead_key_next;

    // result registers
    logic               done_reg, done_next;
    logic               granted_reg, granted_next;
    logic [ID_W-1:0]    grant_id_reg, grant_id_next;
    logic               rejected_reg, rejected_next;
    logic               busy_res_reg, busy_res_next;
    logic [COUNT_W-1:0] waiting_reg, waiting_next;

    // slot store interface
    logic                    slot_wr_en;
    logic [IDX_W-1:0]        slot_wr_idx;
    slot_entry_t             slot_wr_data;
    logic                    slot_clr_en;
    logic [IDX_W-1:0]        slot_clr_idx;
    logic [IDX_W-1:0]        slot_rd_idx;
    slot_entry_t             slot_rd_data;
    logic [WAITER_SLOTS-1:0] slot_active;

    // compare unit interface
    logic [TIME_W-1:0] cmp_a;
    logic [TIME_W-1:0] cmp_b;
    cmp_res_t          cmp_res;

    // helpers
    logic              accept;
    logic              full;
    logic [IDX_W-1:0]  free_idx;
    logic [TIME_W:0]   dl_sum;
    logic [TIME_W-1:0] deadline;
    logic [TIME_W:0]   cool_sum;
    logic              cool_over;
    logic              grant_ok;
    logic [COUNT_W-1:0] active_cnt;
    logic [TIME_W-1:0] scan_key;

    // apb port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_comb
    begin
        case (paddr[3:2])
            REG_POLICY:   prdata = {31'd0, policy_reg};
            REG_COOLDOWN: prdata = {16'd0, cooldown_reg};
            REG_BURNOUT:  prdata = {16'd0, burnout_reg};
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg   <= POL_ARRIVAL;
            cooldown_reg <= '0;
            burnout_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_POLICY:   policy_reg   <= pwdata[0];
                REG_COOLDOWN: cooldown_reg <= pwdata[15:0];
                REG_BURNOUT:  burnout_reg  <= pwdata[15:0];
                default:      ;
            endcase
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign accept = start & ~busy;

    // slot store and shared comparator
    rgac_slots #(
        .WAITER_SLOTS(WAITER_SLOTS),
        .IDX_W       (IDX_W)
    ) u_slots (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (slot_wr_en),
        .wr_idx (slot_wr_idx),
        .wr_data(slot_wr_data),
        .clr_en (slot_clr_en),
        .clr_idx(slot_clr_idx),
        .rd_idx (slot_rd_idx),
        .rd_data(slot_rd_data),
        .active (slot_active)
    );

    rgac_cmp u_cmp (
        .a  (cmp_a),
        .b  (cmp_b),
        .res(cmp_res)
    );

    // lowest free slot
    always_comb
    begin
        full     = 1'b1;
        free_idx = '0;
        for (int s = WAITER_SLOTS - 1; s >= 0; s--)
        begin
            if (!slot_active[s])
            begin
                full     = 1'b0;
                free_idx = IDX_W'(s);
            end
        end
    end

    // active slot count
    always_comb
    begin
        active_cnt = '0;
        for (int s = 0; s < WAITER_SLOTS; s++)
        begin
            active_cnt = active_cnt + COUNT_W'(slot_active[s]);
        end
    end

    // saturating deadline
    assign dl_sum   = {1'b0, start_reg} + {17'd0, burnout_reg};
    assign deadline = dl_sum[TIME_W] ? TIME_MAX : dl_sum[TIME_W-1:0];

    // cooldown test: release time plus cooldown strictly below now
    assign cool_sum  = {1'b0, rel_time_reg} + {17'd0, cooldown_reg};
    assign cool_over = ~ever_rel_reg | (cool_sum < {1'b0, now_reg});
    assign grant_ok  = ~held_reg & cool_over & best_valid_reg;

    // compare operands: owner match while withdrawing, key order while picking
    assign scan_key = (policy_reg == POL_DEADLINE) ? slot_rd_data.deadline
                                                   : slot_rd_data.arrival;
    always_comb
    begin
        if (state_reg == S_WDRAW)
        begin
            cmp_a = {{(TIME_W-ID_W){1'b0}}, slot_rd_data.owner};
            cmp_b = {{(TIME_W-ID_W){1'b0}}, id_reg};
        end
        else
        begin
            cmp_a = scan_key;
            cmp_b = lead_key_reg;
        end
    end

    assign slot_rd_idx = (state_reg == S_DONE) ? best_idx_reg : idx_reg;

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        now_next        = now_reg;
        held_next       = held_reg;
        ever_rel_next   = ever_rel_reg;
        rel_time_next   = rel_time_reg;
        best_valid_next = best_valid_reg;
        best_idx_next   = best_idx_reg;
        lead_key_next   = lead_key_reg;
        rej_next        = rej_reg;
        done_next       = 1'b0;
        granted_next    = granted_reg;
        grant_id_next   = grant_id_reg;
        rejected_next   = rejected_reg;
        busy_res_next   = busy_res_reg;
        waiting_next    = waiting_reg;
        slot_wr_en      = 1'b0;
        slot_wr_idx     = free_idx;
        slot_wr_data.owner    = id_reg;
        slot_wr_data.arrival  = now_reg;
        slot_wr_data.deadline = deadline;
        slot_clr_en     = 1'b0;
        slot_clr_idx    = idx_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_ACT;
                end
            end

            // apply the action
            S_ACT:
            begin
                rej_next        = 1'b0;
                best_valid_next = 1'b0;
                idx_next        = '0;
                state_next      = S_PICK;
                case (act_reg)
                    ACT_TICK:
                    begin
                        if (now_reg != TIME_MAX)
                        begin
                            now_next = now_reg + 1'b1;
                        end
                    end
                    ACT_REQUEST:
                    begin
                        if (full)
                        begin
                            rej_next = 1'b1;
                        end
                        else
                        begin
                            slot_wr_en = 1'b1;
                        end
                    end
                    ACT_RELEASE:
                    begin
                        held_next     = 1'b0;
                        ever_rel_next = 1'b1;
                        rel_time_next = now_reg;
                    end
                    default:
                    begin
                        state_next = S_WDRAW;
                    end
                endcase
            end

            // find and clear the lowest slot owned by the requester
            S_WDRAW:
            begin
                if (slot_active[idx_reg] && cmp_res.eq)
                begin
                    slot_clr_en = 1'b1;
                    idx_next    = '0;
                    state_next  = S_PICK;
                end
                else if (idx_reg == IDX_LAST)
                begin
                    idx_next   = '0;
                    state_next = S_PICK;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            // smallest key, lower slot on ties
            S_PICK:
            begin
                if (slot_active[idx_reg] && (!best_valid_reg || cmp_res.lt))
                begin
                    best_valid_next = 1'b1;
                    best_idx_next   = idx_reg;
                    lead_key_next   = scan_key;
                end
                if (idx_reg == IDX_LAST)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            // apply the grant and register the result
            S_DONE:
            begin
                done_next     = 1'b1;
                rejected_next = rej_reg;
                slot_clr_idx  = best_idx_reg;
                if (grant_ok)
                begin
                    slot_clr_en   = 1'b1;
                    held_next     = 1'b1;
                    granted_next  = 1'b1;
                    grant_id_next = slot_rd_data.owner;
                    busy_res_next = 1'b1;
                    waiting_next  = active_cnt - 1'b1;
                end
                else
                begin
                    granted_next  = 1'b0;
                    grant_id_next = '0;
                    busy_res_next = held_reg;
                    waiting_next  = active_cnt;
                end
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            now_reg        <= '0;
            held_reg       <= 1'b0;
            ever_rel_reg   <= 1'b0;
            rel_time_reg   <= '0;
            best_valid_reg <= 1'b0;
            rej_reg        <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            now_reg        <= now_next;
            held_reg       <= held_next;
            ever_rel_reg   <= ever_rel_next;
            rel_time_reg   <= rel_time_next;
            best_valid_reg <= best_valid_next;
            rej_reg        <= rej_next;
            done_reg       <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg   <= action;
            id_reg    <= requester_id;
            start_reg <= compile_start;
        end
        best_idx_reg <= best_idx_next;
        lead_key_reg <= lead_key_next;
        granted_reg  <= granted_next;
        grant_id_reg <= grant_id_next;
        rejected_reg <= rejected_next;
        busy_res_reg <= busy_res_next;
        waiting_reg  <= waiting_next;
    end

    assign done     = done_reg;
    assign granted  = granted_reg;
    assign grant_id = grant_id_reg;
    assign rejected = rejected_reg;
    assign busy_res = busy_res_reg;
    assign waiting  = waiting_reg;

    // checks
    a_done_after_grant_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |=> done_reg)
        else $error("result strobe missing after grant step");

    a_done_only_from_grant_step: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == S_DONE))
        else $error("result strobe without grant step");

    a_grant_holds_resource: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && granted_reg) |-> (busy_res_reg && held_reg))
        else $error("grant reported while resource free");

    a_reject_only_request: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && rejected_reg) |-> (act_reg == ACT_REQUEST))
        else $error("reject on an action other than request");

    a_waiting_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (waiting_reg <= COUNT_W'(WAITER_SLOTS)))
        else $error("waiter count above slot count");

endmodule

@@ rtl/rgac_cmp.sv @@
// shared key compare unit: unsigned less-than and equality on 32-bit keys
// depends on rgac_pkg
module rgac_cmp
    import rgac_pkg::*;
(
    input  logic [TIME_W-1:0] a,
    input  logic [TIME_W-1:0] b,
    output cmp_res_t          res
);

    // one magnitude compare and one equality test
    always_comb
    begin
        res.lt = (a < b);
        res.eq = (a == b);
    end

endmodule

@@ rtl/rgac_slots.sv @@
// waiter slot store: active bits plus owner, arrival and deadline per slot
// depends on rgac_pkg
module rgac_slots
    import rgac_pkg::*;
#(
    parameter int WAITER_SLOTS = 2,
    parameter int IDX_W        = 1
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    wr_en,
    input  logic [IDX_W-1:0]        wr_idx,
    input  slot_entry_t             wr_data,
    input  logic                    clr_en,
    input  logic [IDX_W-1:0]        clr_idx,
    input  logic [IDX_W-1:0]        rd_idx,
    output slot_entry_t             rd_data,
    output logic [WAITER_SLOTS-1:0] active
);

    logic [WAITER_SLOTS-1:0] active_reg;
    logic [WAITER_SLOTS-1:0] active_next;
    slot_entry_t             entry_reg [WAITER_SLOTS];

    // active bits: set on write, cleared on grant or withdraw
    always_comb
    begin
        active_next = active_reg;
        if (wr_en)
        begin
            active_next[wr_idx] = 1'b1;
        end
        if (clr_en)
        begin
            active_next[clr_idx] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

    // slot payload, no reset
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_idx] <= wr_data;
        end
    end

    assign rd_data = entry_reg[rd_idx];
    assign active  = active_reg;

endmodule
